// File: design/linear_queue_duplicate_reject_macros.svh
// Assertion helpers for the duplicate-reject queue.
`ifndef LINEAR_QUEUE_DUPLICATE_REJECT_MACROS_SVH
`define LINEAR_QUEUE_DUPLICATE_REJECT_MACROS_SVH

`ifndef SYNTHESIS
`define LQDR_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: implication check failed");
`define LQDR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");
`else
`define LQDR_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define LQDR_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// File: design/lqdr_pkg.sv
`default_nettype none

package lqdr_pkg;

	localparam int DEPTH_DEFAULT = 32;
	localparam int CAP_W         = 6;
	localparam int DATA_W        = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

	// operation codes
	localparam logic [1:0] OP_ENQ  = 2'd0;
	localparam logic [1:0] OP_DEQ  = 2'd1;
	localparam logic [1:0] OP_DISP = 2'd2;
	localparam logic [1:0] OP_RSVD = 2'd3;

	// status codes
	localparam logic [2:0] STS_OK    = 3'd0;
	localparam logic [2:0] STS_DUP   = 3'd1;
	localparam logic [2:0] STS_OVF   = 3'd2;
	localparam logic [2:0] STS_UNF   = 3'd3;
	localparam logic [2:0] STS_SHOWN = 3'd4;
	localparam logic [2:0] STS_EMPTY = 3'd5;

	typedef struct packed {
		logic [1:0]               operation;
		logic signed [DATA_W-1:0] value;
	} lqdr_in_t;

	typedef struct packed {
		logic [2:0]               status;
		logic signed [DATA_W-1:0] element;
		logic                     last;
	} lqdr_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SINGLE,
		ST_WALK
	} lqdr_state_t;

endpackage

`default_nettype wire

// File: design/lqdr_ram.sv
`default_nettype none

// Simple dual-port RAM, one write and one registered read port.
module lqdr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: design/linear_queue_duplicate_reject.sv
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall   | in_data  (operation, value)
// out     | output    | out_valid / out_stall | out_data (status, element, last)
// cfg     | input     | cfg_valid / cfg_ready | cfg_data (capacity)
//
// Dequeue, and enqueue or display on an empty queue, need no RAM read.
// Enqueue and display walk the n live entries through the one RAM read port
// and one 32-bit comparator, one entry per cycle while the output is not stalled.
// Reset (arst_n low) zeroes head and fill, returns capacity to 32 and drops
// out_valid; the RAM is not cleared, as only written slots are ever read.
// A stalled output pauses the walk; in_stall is high while a walk is active.
`default_nettype none

`include "linear_queue_duplicate_reject_macros.svh"

module linear_queue_duplicate_reject #(
	parameter int DEPTH = lqdr_pkg::DEPTH_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire lqdr_pkg::lqdr_in_t                in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output lqdr_pkg::lqdr_out_t                    out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [lqdr_pkg::CAP_W-1:0]        cfg_data
);

	import lqdr_pkg::*;

	// PW holds 0..DEPTH, AW addresses the RAM
	localparam int PW   = $clog2(DEPTH + 1);
	localparam int AW   = $clog2(DEPTH);
	localparam int CMPW = (PW > CAP_W) ? PW : CAP_W;

	lqdr_state_t state_q, state_d;

	logic [CAP_W-1:0]  cap_q;
	logic [1:0]        op_q;
	logic [DATA_W-1:0] val_q;
	logic [PW-1:0]     head_q, head_d;
	logic [PW-1:0]     fill_q, fill_d;
	logic [PW-1:0]     rd_idx_q, rd_idx_d;  // next slot to read
	logic [PW-1:0]     cmp_idx_q, cmp_idx_d; // slot now in rd_data
	logic              pend_q, pend_d;      // rd_data holds an unchecked entry

	logic              out_valid_q;
	lqdr_out_t         out_data_q;
	lqdr_out_t         emit_data;
	logic              emit;
	logic              out_free;
	logic              accept;

	logic              wr_en;
	logic              rd_en;
	logic [DATA_W-1:0] rd_data;

	logic              empty;
	logic              full;
	logic              last_cmp;
	logic              match;
	logic              consume;
	logic              leaving;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign empty    = (head_q >= fill_q);
	// effective limit is min(capacity, DEPTH)
	assign full     = (CMPW'(fill_q) >= CMPW'(cap_q)) || (fill_q >= PW'(DEPTH));
	assign last_cmp = ((cmp_idx_q + PW'(1)) == fill_q);
	assign match    = (rd_data == val_q);

	lqdr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (val_q),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cap_q       <= CAP_RESET;
			head_q      <= '0;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			cmp_idx_q   <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			fill_q    <= fill_d;
			rd_idx_q  <= rd_idx_d;
			cmp_idx_q <= cmp_idx_d;
			pend_q    <= pend_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= in_data.operation;
			val_q <= in_data.value;
		end
		if (emit) begin
			out_data_q <= emit_data;
		end
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		fill_d    = fill_q;
		rd_idx_d  = rd_idx_q;
		cmp_idx_d = cmp_idx_q;
		pend_d    = pend_q;
		emit      = 1'b0;
		emit_data = '0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		consume   = 1'b0;
		leaving   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				pend_d = 1'b0;
				if (in_valid) begin
					unique case (in_data.operation)
						OP_ENQ, OP_DISP: begin
							if (empty) begin
								state_d = ST_SINGLE;
							end else begin
								state_d  = ST_WALK;
								rd_idx_d = head_q;
							end
						end
						OP_DEQ: begin
							state_d = ST_SINGLE;
						end
						OP_RSVD: begin
							state_d = ST_IDLE;  // no result, no change
						end
					endcase
				end
			end

			ST_SINGLE: begin
				if (out_free) begin
					state_d        = ST_IDLE;
					emit           = 1'b1;
					emit_data.last = 1'b1;
					unique case (op_q)
						OP_ENQ: begin
							if (full) begin
								emit_data.status = STS_OVF;
							end else begin
								emit_data.status = STS_OK;
								wr_en            = 1'b1;
								fill_d           = fill_q + PW'(1);
							end
						end
						OP_DEQ: begin
							if (empty) begin
								emit_data.status = STS_UNF;
							end else begin
								emit_data.status = STS_OK;
								head_d           = head_q + PW'(1);
							end
						end
						OP_DISP: begin
							emit_data.status = STS_EMPTY;
						end
						OP_RSVD: begin
							emit = 1'b0;
						end
					endcase
				end
			end

			ST_WALK: begin
				consume = pend_q && out_free;
				if (consume) begin
					if (op_q == OP_DISP) begin
						emit              = 1'b1;
						emit_data.status  = STS_SHOWN;
						emit_data.element = rd_data;
						emit_data.last    = last_cmp;
						leaving           = last_cmp;
					end else if (match) begin
						emit             = 1'b1;
						emit_data.status = STS_DUP;
						emit_data.last   = 1'b1;
						leaving          = 1'b1;
					end else if (last_cmp) begin
						// searched every live entry: append or overflow
						emit           = 1'b1;
						emit_data.last = 1'b1;
						leaving        = 1'b1;
						if (full) begin
							emit_data.status = STS_OVF;
						end else begin
							emit_data.status = STS_OK;
							wr_en            = 1'b1;
							fill_d           = fill_q + PW'(1);
						end
					end
				end

				if (leaving) begin
					state_d = ST_IDLE;
					pend_d  = 1'b0;
				end else if ((!pend_q || consume) && (rd_idx_q < fill_q)) begin
					rd_en     = 1'b1;
					rd_idx_d  = rd_idx_q + PW'(1);
					cmp_idx_d = rd_idx_q;
					pend_d    = 1'b1;
				end else if (consume) begin
					pend_d = 1'b0;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`LQDR_ASSERT_IMPL(a_head_le_fill, clk, arst_n, 1'b1, head_q <= fill_q)
	`LQDR_ASSERT_IMPL(a_write_only_on_ok, clk, arst_n, wr_en, emit && (emit_data.status == STS_OK))
	`LQDR_ASSERT_NEXT(a_fill_steps_by_one, clk, arst_n, 1'b1, (fill_q - $past(fill_q)) <= PW'(1))
	`LQDR_ASSERT_IMPL(a_read_in_walk, clk, arst_n, rd_en, (state_q == ST_WALK) && (rd_idx_q < fill_q))

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import lqdr_pkg::*;

	localparam int DEPTH       = DEPTH_DEFAULT;
	// Worst case is about 230 transactions, each a full 32-entry display with
	// every result held by the longest output stall. The limit sits well above that.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYC  = DEPTH + 8;
	localparam int PHASES      = 7;
	localparam int PHASE_ITEMS = 30;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	lqdr_in_t  in_data;
	logic      out_valid;
	logic      out_stall;
	lqdr_out_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [CAP_W-1:0] cfg_data;

	linear_queue_duplicate_reject u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the queue: slots, head, fill and capacity register.
	// Updated once per accepted input transaction, at the same edge.
	// ------------------------------------------------------------------
	logic [DATA_W-1:0] shadow_slot [DEPTH];
	int unsigned       shadow_head = 0;
	int unsigned       shadow_fill = 0;
	int unsigned       shadow_cap  = 32'(CAP_RESET);

	lqdr_out_t step_out[$];     // results of the transaction just applied
	lqdr_out_t due_results[$];  // results still owed by the block, oldest first

	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;

	// Expectation typed into the directed table for the transaction in flight.
	bit          row_typed  = 1'b0;
	logic [2:0]  row_status = STS_OK;

	function automatic void shadow_apply(input lqdr_in_t item);
		int unsigned lim;
		int unsigned i;
		bit          hit;
		lqdr_out_t   r;
		step_out.delete();
		// capacity above the array size is clamped to it
		lim = (shadow_cap < DEPTH) ? shadow_cap : DEPTH;
		r = '0;
		r.last = 1'b1;
		case (item.operation)
			OP_ENQ: begin
				// duplicate search runs first, so it wins over overflow;
				// an empty queue never holds a duplicate
				hit = 1'b0;
				for (i = shadow_head; i < shadow_fill; i++)
					if (shadow_slot[i] == item.value)
						hit = 1'b1;
				if (hit) begin
					r.status = STS_DUP;
				end else if (shadow_fill >= lim) begin
					r.status = STS_OVF;
				end else begin
					shadow_slot[shadow_fill] = item.value;
					shadow_fill++;
					r.status = STS_OK;
				end
				step_out.push_back(r);
			end
			OP_DEQ: begin
				if (shadow_head >= shadow_fill) begin
					r.status = STS_UNF;
				end else begin
					shadow_head++;
					r.status = STS_OK;
				end
				step_out.push_back(r);
			end
			OP_DISP: begin
				if (shadow_head >= shadow_fill) begin
					r.status = STS_EMPTY;
					step_out.push_back(r);
				end else begin
					for (i = shadow_head; i < shadow_fill; i++) begin
						r.status  = STS_SHOWN;
						r.element = shadow_slot[i];
						r.last    = (i + 1 == shadow_fill);
						step_out.push_back(r);
					end
				end
			end
			default: ; // reserved code: no state change, no result
		endcase
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		// keep the log short if the block is badly broken
		if (mismatch_count < 50)
			$display("tb: mismatch at %0t: %s got %0h expected %0h",
				$time, what, got, want);
		mismatch_count++;
	endtask

	// ------------------------------------------------------------------
	// Monitor: everything sampled at the rising edge. Prediction runs before
	// the result check; the output is registered, so a transaction never
	// produces a result at the edge that accepts it.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : watch
		lqdr_out_t want;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				shadow_apply(in_data);
				if (row_typed) begin
					want = '0;
					want.status = row_status;
					want.last = 1'b1;
					due_results.push_back(want);
				end else begin
					foreach (step_out[j])
						due_results.push_back(step_out[j]);
				end
			end
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					flag_mismatch("result with nothing expected, status",
						32'(out_data.status), 32'd0);
				end else begin
					want = due_results.pop_front();
					if (out_data.status !== want.status)
						flag_mismatch("status", 32'(out_data.status), 32'(want.status));
					if (out_data.element !== want.element)
						flag_mismatch("element", out_data.element, want.element);
					if (out_data.last !== want.last)
						flag_mismatch("last", 32'(out_data.last), 32'(want.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Output back-pressure: short stalls, a few long ones, and quiet stretches.
	initial begin : out_pacing
		int unsigned pick;
		int unsigned span;
		out_stall = 1'b0;
		forever begin
			pick = $urandom_range(99, 0);
			if (pick < 10) begin
				out_stall = 1'b0;
				span = $urandom_range(80, 30);
			end else if (pick < 55) begin
				out_stall = 1'b0;
				span = $urandom_range(4, 1);
			end else if (pick < 92) begin
				out_stall = 1'b1;
				span = $urandom_range(3, 1);
			end else begin
				out_stall = 1'b1;
				span = $urandom_range(25, 10);
			end
			repeat (span) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------
	// Input side. All tasks start and end at a falling edge.
	// ------------------------------------------------------------------
	int unsigned steady_left = 0;

	// Idle gap after a transaction. in_valid drops only when a gap is taken,
	// so back-to-back transactions keep it high without a glitch.
	task automatic input_gap();
		int unsigned pick;
		int unsigned span;
		pick = $urandom_range(99, 0);
		if (steady_left != 0) begin
			steady_left--;
			span = 0;
		end else if (pick < 5) begin
			steady_left = $urandom_range(30, 10);
			span = 0;
		end else if (pick < 55) begin
			span = 0;
		end else if (pick < 90) begin
			span = $urandom_range(3, 1);
		end else begin
			span = $urandom_range(30, 10);
		end
		if (span != 0) begin
			in_valid = 1'b0;
			repeat (span) @(negedge clk);
		end
	endtask

	task automatic send_op(input logic [1:0] op, input logic [DATA_W-1:0] val,
			input bit typed, input logic [2:0] st);
		in_data.operation = op;
		in_data.value     = val;
		row_typed  = typed;
		row_status = st;
		in_valid   = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		input_gap();
	endtask

	// Wait for every owed result, then give the block time to finish any
	// transaction that owes none (reserved code) before touching the register.
	task automatic settle();
		in_valid = 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		settle();
		cfg_data  = cap;
		cfg_valid = 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		shadow_cap = 32'(cap);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Directed table. Register rows carry the capacity in val.
	// ------------------------------------------------------------------
	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t         kind;
		logic [1:0]        op;
		logic [DATA_W-1:0] val;
		bit                typed;
		logic [2:0]        st;
	} row_t;

	row_t plan [26] = '{
		'{ROW_ITEM, OP_DISP, 32'h0000_0000, 1'b1, STS_EMPTY}, // empty after reset
		'{ROW_ITEM, OP_DEQ,  32'h0000_0000, 1'b1, STS_UNF},
		'{ROW_ITEM, OP_RSVD, 32'hdead_beef, 1'b0, STS_OK},    // ignored, no result
		'{ROW_ITEM, OP_ENQ,  32'h7fff_ffff, 1'b1, STS_OK},    // enqueue into an empty queue
		'{ROW_ITEM, OP_ENQ,  32'h8000_0000, 1'b1, STS_OK},
		'{ROW_ITEM, OP_ENQ,  32'h0000_0000, 1'b1, STS_OK},
		'{ROW_ITEM, OP_ENQ,  32'h8000_0000, 1'b1, STS_DUP},
		'{ROW_ITEM, OP_DISP, 32'h0000_0000, 1'b0, STS_OK},
		'{ROW_ITEM, OP_DEQ,  32'hffff_ffff, 1'b1, STS_OK},
		'{ROW_ITEM, OP_ENQ,  32'h7fff_ffff, 1'b0, STS_OK},    // freed value is not a dup
		'{ROW_CFG,  OP_ENQ,  32'd0,         1'b0, STS_OK},    // capacity zero
		'{ROW_ITEM, OP_ENQ,  32'h0000_0005, 1'b1, STS_OVF},
		'{ROW_ITEM, OP_ENQ,  32'h0000_0000, 1'b1, STS_DUP},   // dup wins while full
		'{ROW_CFG,  OP_ENQ,  32'd2,         1'b0, STS_OK},    // lowered below fill
		'{ROW_ITEM, OP_ENQ,  32'hffff_ffff, 1'b1, STS_OVF},
		'{ROW_CFG,  OP_ENQ,  32'd63,        1'b0, STS_OK},    // clamped to the array size
		'{ROW_ITEM, OP_ENQ,  32'hffff_ffff, 1'b1, STS_OK},
		'{ROW_ITEM, OP_DISP, 32'hffff_ffff, 1'b0, STS_OK},
		'{ROW_ITEM, OP_DEQ,  32'h0000_0000, 1'b0, STS_OK},
		'{ROW_ITEM, OP_DEQ,  32'h0000_0000, 1'b0, STS_OK},
		'{ROW_ITEM, OP_DEQ,  32'h0000_0000, 1'b0, STS_OK},
		'{ROW_ITEM, OP_DEQ,  32'h0000_0000, 1'b0, STS_OK},
		'{ROW_ITEM, OP_DEQ,  32'h0000_0000, 1'b1, STS_UNF},
		'{ROW_ITEM, OP_DISP, 32'h0000_0000, 1'b1, STS_EMPTY},
		'{ROW_ITEM, OP_ENQ,  32'h8000_0000, 1'b0, STS_OK},
		'{ROW_CFG,  OP_ENQ,  32'd32,        1'b0, STS_OK}
	};

	initial begin : run
		int unsigned       phase;
		int unsigned       n;
		int unsigned       pick;
		int unsigned       cap;
		logic [1:0]        op;
		logic [DATA_W-1:0] val;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[k]) begin
			if (plan[k].kind == ROW_CFG)
				write_capacity(plan[k].val[CAP_W-1:0]);
			else
				send_op(plan[k].op, plan[k].val, plan[k].typed, plan[k].st);
		end

		// Random phases. Slots are never reused, so in phases 0, 2 and 4 capacity is
		// set 2 to 8 slots past the fill position: overflow keeps recurring while the
		// queue fills slowly, and the later phases let it reach the array size.
		for (phase = 0; phase < PHASES; phase++) begin
			case (phase)
				1:       cap = 0;
				3:       cap = $urandom_range(DEPTH, 1);
				5:       cap = 63;
				6:       cap = DEPTH;
				default: cap = shadow_fill + $urandom_range(8, 2);
			endcase
			if (cap > 63)
				cap = 63;
			write_capacity(cap[CAP_W-1:0]);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99, 0);
				if (pick < 45)
					op = OP_ENQ;
				else if (pick < 65)
					op = OP_DEQ;
				else if (pick < 93)
					op = OP_DISP;
				else
					op = OP_RSVD;
				val = $urandom;
				if (op == OP_ENQ) begin
					pick = $urandom_range(99, 0);
					if (shadow_head < shadow_fill && pick < 35)
						val = shadow_slot[$urandom_range(shadow_fill - 1, shadow_head)];
					else if (pick < 45)
						case ($urandom_range(3, 0))
							0:       val = 32'h0000_0000;
							1:       val = 32'h8000_0000;
							2:       val = 32'h7fff_ffff;
							default: val = 32'hffff_ffff;
						endcase
				end
				send_op(op, val, 1'b0, STS_OK);
			end
		end

		settle();
		if (mismatch_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
